@@ rtl/aes128_block_cipher_macros.svh @@
// Assertion macros for the AES-128 block cipher
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH
// Implication check under synchronous reset
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication check
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/aes_pkg.sv @@
// Shared types, constants and byte functions for the AES-128 block cipher
package aes_pkg;
    localparam int unsigned NumRounds = 10;
    localparam int unsigned NumCfgRegs = 3;

    typedef enum logic [1:0] {
        t_reg_key_high = 2'd0,
        t_reg_key_low  = 2'd1,
        t_reg_mode     = 2'd2
    } t_reg_idx;

    typedef logic [127:0] t_block;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ x;
            x = xtime(x);
        end
        gmul = acc;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] s [256] = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        sbox = s[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] s [256] = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        inv_sbox = s[x];
    endfunction

    // byte i of the block sits in bits 127-8i -: 8
    function automatic logic [7:0] get_byte(input t_block b, input int i);
        get_byte = b[127 - 8*i -: 8];
    endfunction

    function automatic t_block enc_round(input t_block s, input t_block rk, input logic last);
        t_block sh;
        t_block o;
        logic [7:0] c0, c1, c2, c3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sh[127 - 8*(c*4+r) -: 8] = sbox(get_byte(s, ((c + r) % 4)*4 + r));
        o = sh;
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                c0 = get_byte(sh, c*4);
                c1 = get_byte(sh, c*4+1);
                c2 = get_byte(sh, c*4+2);
                c3 = get_byte(sh, c*4+3);
                o[127 - 8*(c*4) -: 8]   = xtime(c0) ^ xtime(c1) ^ c1 ^ c2 ^ c3;
                o[127 - 8*(c*4+1) -: 8] = c0 ^ xtime(c1) ^ xtime(c2) ^ c2 ^ c3;
                o[127 - 8*(c*4+2) -: 8] = c0 ^ c1 ^ xtime(c2) ^ xtime(c3) ^ c3;
                o[127 - 8*(c*4+3) -: 8] = xtime(c0) ^ c0 ^ c1 ^ c2 ^ xtime(c3);
            end
        end
        enc_round = o ^ rk;
    endfunction

    function automatic t_block dec_round(input t_block s, input t_block rk, input logic last);
        t_block sh;
        t_block o;
        logic [7:0] c0, c1, c2, c3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sh[127 - 8*(((c + r) % 4)*4 + r) -: 8] = inv_sbox(get_byte(s, c*4 + r));
        sh = sh ^ rk;
        o = sh;
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                c0 = get_byte(sh, c*4);
                c1 = get_byte(sh, c*4+1);
                c2 = get_byte(sh, c*4+2);
                c3 = get_byte(sh, c*4+3);
                o[127 - 8*(c*4) -: 8]   = gmul(c0, 8'd14) ^ gmul(c1, 8'd11)
                                        ^ gmul(c2, 8'd13) ^ gmul(c3, 8'd9);
                o[127 - 8*(c*4+1) -: 8] = gmul(c0, 8'd9) ^ gmul(c1, 8'd14)
                                        ^ gmul(c2, 8'd11) ^ gmul(c3, 8'd13);
                o[127 - 8*(c*4+2) -: 8] = gmul(c0, 8'd13) ^ gmul(c1, 8'd9)
                                        ^ gmul(c2, 8'd14) ^ gmul(c3, 8'd11);
                o[127 - 8*(c*4+3) -: 8] = gmul(c0, 8'd11) ^ gmul(c1, 8'd13)
                                        ^ gmul(c2, 8'd9) ^ gmul(c3, 8'd14);
            end
        end
        dec_round = o;
    endfunction

    // next round key from the previous one and the round constant
    function automatic t_block next_key(input t_block k, input logic [7:0] rc);
        logic [31:0] t;
        t_block o;
        t = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
        o[127:96] = k[127:96] ^ t;
        o[95:64]  = k[95:64] ^ o[127:96];
        o[63:32]  = k[63:32] ^ o[95:64];
        o[31:0]   = k[31:0] ^ o[63:32];
        next_key = o;
    endfunction

    function automatic logic [7:0] rcon(input int unsigned n);
        logic [7:0] r;
        r = 8'h01;
        for (int unsigned i = 0; i < NumRounds; i++)
            if (i < n) r = xtime(r);
        rcon = r;
    endfunction
endpackage

@@ rtl/aes_stream_if.sv @@
// Valid/ready channel carrying one 128-bit block as two halves
interface aes_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;
    modport source (output valid, output data_high, output data_low, input ready);
    modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

@@ rtl/aes128_block_cipher.sv @@
// AES-128 ECB top level: key schedule, whitening register, ten round cells
// Usage:
//   Configuration: write key_high (index 0), key_low (1) and decrypt_mode (2)
//   through i_cfg_we/i_cfg_idx/i_cfg_data while no block is in flight.
//   A key write loads the new key, then rebuilds the round keys one round a
//   cycle; input is held off meanwhile.
//   Input channel in_ch: a transfer carries one block (byte 0 in top bits of
//   data_high). Output channel out_ch returns the encrypted/decrypted block.
// Path: one whitening register plus ten round cells lie between input transfer
//   and output valid, the last cell driving the output.
// Throughput: one block per cycle unless held off; all cells advance together.
// Stall: when out_ch.ready is low and the last cell holds a block, the whole
//   row freezes and in_ch.ready drops; bubbles are not squeezed out, and
//   nothing is lost or repeated.
// Reset: synchronous active-low; clears keys to zero, encrypt mode, empties
//   the row and builds the all-zero key schedule (input held off meanwhile).
module aes128_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    aes_stream_if.sink   in_ch,
    aes_stream_if.source out_ch
);
    import aes_pkg::*;
    `include "aes128_block_cipher_macros.svh"

    logic [63:0] r_key_high, r_key_low;
    logic        r_dec;
    logic        r_load;
    logic        ks_busy;
    t_block      rk [NumRounds + 1];
    logic        adv;
    logic        v    [NumRounds + 1];
    t_block      st   [NumRounds + 1];
    logic        r_v0;
    t_block      r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_dec      <= 1'b0;
            r_load     <= 1'b0;
        end else begin
            r_load <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    t_reg_key_high: begin r_key_high <= i_cfg_data; r_load <= 1'b1; end
                    t_reg_key_low:  begin r_key_low  <= i_cfg_data; r_load <= 1'b1; end
                    t_reg_mode:     r_dec <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    aes_key_sched u_ks (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(r_load),
        .i_key({r_key_high, r_key_low}), .o_busy(ks_busy), .o_rk(rk)
    );

    // last cell output stalls the row when the receiver holds off
    assign adv = !(v[NumRounds] && !out_ch.ready);
    assign in_ch.ready = adv && !ks_busy && !r_load;

    // initial key whitening register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (adv) r_v0 <= in_ch.valid && in_ch.ready;
    end
    always_ff @(posedge i_clk) begin
        if (adv) r_s0 <= {in_ch.data_high, in_ch.data_low} ^ (r_dec ? rk[NumRounds] : rk[0]);
    end

    assign v[0]  = r_v0;
    assign st[0] = r_s0;

    for (genvar g = 1; g <= NumRounds; g++) begin : g_cell
        aes_round_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_dec(r_dec),
            .i_last(g == NumRounds), .i_valid(v[g-1]), .i_state(st[g-1]),
            .i_rk(r_dec ? rk[NumRounds - g] : rk[g]),
            .o_valid(v[g]), .o_state(st[g])
        );
    end

    assign out_ch.valid     = v[NumRounds];
    assign out_ch.data_high = st[NumRounds][127:64];
    assign out_ch.data_low  = st[NumRounds][63:0];

    `AES_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n,
        out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data_high))
    `AES_ASSERT_IMP(a_no_in_during_ks, i_clk, i_rst_n, ks_busy, !in_ch.ready)
    `AES_ASSERT_IMP(a_stall_blocks_in, i_clk, i_rst_n,
        out_ch.valid && !out_ch.ready, !in_ch.ready)
endmodule

@@ rtl/aes_key_sched.sv @@
// Round key table rebuilt after reset and after each key load, one round a cycle
module aes_key_sched (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  aes_pkg::t_block         i_key,
    output logic                    o_busy,
    output aes_pkg::t_block         o_rk [aes_pkg::NumRounds + 1]
);
    import aes_pkg::*;

    t_block     r_rk [NumRounds + 1];
    logic [3:0] r_cnt;
    logic       r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd1;
            r_rk[0] <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd1;
            r_rk[0] <= i_key;
        end else if (r_busy) begin
            r_rk[r_cnt] <= next_key(r_rk[r_cnt - 4'd1], rcon(32'(r_cnt) - 32'd1));
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'(NumRounds)) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_rk   = r_rk;
endmodule

@@ rtl/aes_round_cell.sv @@
// One round cell: holds a block in flight and hands it to the next cell when enabled
module aes_round_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_dec,
    input  logic            i_last,
    input  logic            i_valid,
    input  aes_pkg::t_block i_state,
    input  aes_pkg::t_block i_rk,
    output logic            o_valid,
    output aes_pkg::t_block o_state
);
    import aes_pkg::*;

    logic   r_valid;
    t_block r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (i_en) r_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_state <= i_dec ? dec_round(i_state, i_rk, i_last)
                             : enc_round(i_state, i_rk, i_last);
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
endmodule
